@@ design/gde_pkg.sv @@
package gde_pkg;

	// concentration and grid geometry
	localparam int CONC_BITS = 16;
	localparam int SIDE_BITS = 8;
	localparam int SIDE_MAX = 1 << SIDE_BITS;
	localparam int SIZE_W = SIDE_BITS + 1;
	localparam int ADDR_W = 2 * SIDE_BITS + 1;
	localparam int BANK_DEPTH = 1 << ADDR_W;
	localparam int CFG_W = 16;
	localparam int MIX_SHIFT = 12;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] MIX_RESET = 16'd41;
	localparam logic [CFG_W-1:0] EVAP_RESET = 16'd3;
	localparam logic [SIZE_W-1:0] ROWS_RESET = 9'd200;
	localparam logic [SIZE_W-1:0] COLS_RESET = 9'd200;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_OUTSIDE = 1'b1;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_DIFFUSE = 2'd1,
		REQ_SWAP = 2'd2,
		REQ_NONE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		REG_MIX = 2'd0,
		REG_EVAP = 2'd1,
		REG_ROWS = 2'd2,
		REG_COLS = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DIV,
		ST_FIX,
		ST_MIX,
		ST_WRITE
	} state_t;

	typedef struct packed {
		req_type_t req_type;
		logic [SIDE_BITS-1:0] row;
		logic [SIDE_BITS-1:0] col;
		logic [CONC_BITS-1:0] ant_in;
		logic [CONC_BITS-1:0] food_in;
		logic food_flag_in;
		logic colony_flag_in;
	} item_t;

	typedef struct packed {
		logic [CONC_BITS-1:0] ant_out;
		logic [CONC_BITS-1:0] food_out;
		logic status;
	} result_t;

	typedef struct packed {
		logic colony_flag;
		logic food_flag;
		logic [CONC_BITS-1:0] food;
		logic [CONC_BITS-1:0] ant;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	// neighbourhood sums and reciprocal division
	localparam int SUM_W = CONC_BITS + 4;
	localparam int RECIP_SH = SUM_W + 4;
	localparam int RECIP_W = RECIP_SH + 1;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int MAG_W = CONC_BITS + CFG_W;
	localparam int STEP_W = MAG_W - MIX_SHIFT + 1;
	localparam int VAL_W = STEP_W + 2;

	localparam longint RECIP_1 = 64'd1 << RECIP_SH;
	localparam longint RECIP_2 = RECIP_1 / 2;
	localparam longint RECIP_3 = RECIP_1 / 3;
	localparam longint RECIP_4 = RECIP_1 / 4;
	localparam longint RECIP_6 = RECIP_1 / 6;
	localparam longint RECIP_9 = RECIP_1 / 9;

	// floor(2^RECIP_SH / count) for the counts a 3x3 window can have
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
		logic [RECIP_W-1:0] r;
		case (count)
			4'd1: r = RECIP_W'(RECIP_1);
			4'd2: r = RECIP_W'(RECIP_2);
			4'd3: r = RECIP_W'(RECIP_3);
			4'd4: r = RECIP_W'(RECIP_4);
			4'd6: r = RECIP_W'(RECIP_6);
			4'd9: r = RECIP_W'(RECIP_9);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ design/gde_ram.sv @@
module gde_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 131072
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ design/grid_diffuse_evaporate_core.sv @@
// two-bank ant/food concentration grid with 3x3 box-blur diffusion and evaporation.
// an item is taken when start is high and busy is low; every item gives exactly one
// result, shown for one cycle with result_valid high, and the receiver cannot stall it.
// load, swap, unused codes and coordinates outside the grid in use leave busy low:
// the result appears in the cycle after the item, so such items can follow each other
// every cycle. a diffuse item inside the grid holds busy until its result is registered:
// the single-port grid memory is read once for each of the nine window positions, then
// a drain step waits out the read, divide and fix steps divide by the in-grid cell count
// through a reciprocal multiply and correction, a mix step multiplies by mix_factor, and
// a write step rounds, clamps and writes the other bank. grid memory is not cleared after
// reset; a diffuse over cells never loaded returns garbage. configuration registers are
// written by the user over the apb port only while the block is idle; it does not check this.
module grid_diffuse_evaporate_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input gde_pkg::item_t item_in,
	output logic result_valid,
	output gde_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [gde_pkg::PADDR_W-1:0] paddr,
	input logic [gde_pkg::PDATA_W-1:0] pwdata,
	output logic [gde_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	import gde_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] mix_q;
	logic [CFG_W-1:0] evap_q;
	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cols_q;
	logic [SIZE_W-1:0] rows_eff;
	logic [SIZE_W-1:0] cols_eff;
	logic cfg_wr;
	cfg_reg_t cfg_sel;

	// sequencer
	state_t state_q, state_d;
	logic bank_q;
	logic accept;
	logic item_inside;
	logic [SIDE_BITS-1:0] row_q;
	logic [SIDE_BITS-1:0] col_q;
	logic [1:0] dr_q;
	logic [1:0] dc_q;
	logic last_pos;
	logic [SIDE_BITS+1:0] nr;
	logic [SIDE_BITS+1:0] nc;
	logic nb_inside;

	// memory port
	logic ram_we;
	logic [ADDR_W-1:0] ram_addr;
	cell_t ram_wdata;
	cell_t ram_rdata;

	// read pipeline and accumulation
	logic rd_s1;
	logic ctr_s1;
	logic [SUM_W-1:0] sum_a_q;
	logic [SUM_W-1:0] sum_f_q;
	logic [3:0] count_q;
	cell_t old_q;

	// division, mixing
	logic [SUM_W-1:0] x_a_q;
	logic [SUM_W-1:0] x_f_q;
	logic [PROD_W-1:0] prod_a_q;
	logic [PROD_W-1:0] prod_f_q;
	logic [CONC_BITS-1:0] blur_a_q;
	logic [CONC_BITS-1:0] blur_f_q;
	logic [CONC_BITS:0] diff_a;
	logic [CONC_BITS:0] diff_f;
	logic [MAG_W-1:0] mag_a_q;
	logic [MAG_W-1:0] mag_f_q;
	logic neg_a_q;
	logic neg_f_q;
	cell_t new_cell;

	result_t result_q;
	logic result_valid_q;

	// reciprocal estimate is at most one low; one compare fixes it
	function automatic logic [CONC_BITS-1:0] div_fix(input logic [SUM_W-1:0] x,
		input logic [PROD_W-1:0] prod, input logic [3:0] count);
		logic [SUM_W-1:0] q0;
		logic [SUM_W+3:0] qd;
		logic [SUM_W+3:0] rem;
		logic [SUM_W-1:0] q;
		q0 = prod[RECIP_SH +: SUM_W];
		qd = (SUM_W+4)'(q0) * (SUM_W+4)'(count);
		rem = (SUM_W+4)'(x) - qd;
		q = (rem >= (SUM_W+4)'(count)) ? q0 + SUM_W'(1) : q0;
		return q[CONC_BITS-1:0];
	endfunction

	// round the step, add it, subtract evaporation, clamp
	function automatic logic [CONC_BITS-1:0] mix_finish(input logic [CONC_BITS-1:0] old,
		input logic [MAG_W-1:0] mag, input logic neg, input logic [CFG_W-1:0] evap);
		logic [MAG_W:0] rnd;
		logic [STEP_W-1:0] stepmag;
		logic [VAL_W-1:0] val;
		logic [CONC_BITS-1:0] res;
		rnd = {1'b0, mag} + (MAG_W+1)'(1 << (MIX_SHIFT - 1));
		stepmag = rnd[MAG_W:MIX_SHIFT];
		val = VAL_W'(old) + (neg ? -VAL_W'(stepmag) : VAL_W'(stepmag)) - VAL_W'(evap);
		if (val[VAL_W-1]) begin
			res = '0;
		end else if (val[VAL_W-2:CONC_BITS] != '0) begin
			res = '1;
		end else begin
			res = val[CONC_BITS-1:0];
		end
		return res;
	endfunction

	// absolute difference of blur and old value
	function automatic logic [CONC_BITS:0] abs_diff(input logic [CONC_BITS-1:0] blur,
		input logic [CONC_BITS-1:0] old);
		logic [CONC_BITS:0] d;
		logic [CONC_BITS:0] m;
		d = {1'b0, blur} - {1'b0, old};
		m = d[CONC_BITS] ? -d : d;
		return {d[CONC_BITS], m[CONC_BITS-1:0]};
	endfunction

	// ---------------------------------------------------------------- configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= MIX_RESET;
			evap_q <= EVAP_RESET;
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_MIX: mix_q <= pwdata[CFG_W-1:0];
				REG_EVAP: evap_q <= pwdata[CFG_W-1:0];
				REG_ROWS: rows_q <= pwdata[SIZE_W-1:0];
				REG_COLS: cols_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_MIX: prdata = PDATA_W'(mix_q);
			REG_EVAP: prdata = PDATA_W'(evap_q);
			REG_ROWS: prdata = PDATA_W'(rows_q);
			REG_COLS: prdata = PDATA_W'(cols_q);
			default: prdata = '0;
		endcase
	end

	// sizes above the grid capacity act as the full grid
	assign rows_eff = (rows_q > SIZE_W'(SIDE_MAX)) ? SIZE_W'(SIDE_MAX) : rows_q;
	assign cols_eff = (cols_q > SIZE_W'(SIDE_MAX)) ? SIZE_W'(SIDE_MAX) : cols_q;

	// ---------------------------------------------------------------- control
	assign busy = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign item_inside = ({1'b0, item_in.row} < rows_eff) && ({1'b0, item_in.col} < cols_eff);

	// window position relative to the center, offsets 0..2 stand for -1..+1
	assign nr = (SIDE_BITS+2)'(row_q) + (SIDE_BITS+2)'(dr_q) - (SIDE_BITS+2)'(1);
	assign nc = (SIDE_BITS+2)'(col_q) + (SIDE_BITS+2)'(dc_q) - (SIDE_BITS+2)'(1);
	assign nb_inside = !nr[SIDE_BITS+1] && !nc[SIDE_BITS+1]
		&& (nr[SIZE_W-1:0] < rows_eff) && (nc[SIZE_W-1:0] < cols_eff);
	assign last_pos = (dr_q == 2'd2) && (dc_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port
	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_addr = '0;
		ram_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && item_inside) begin
					ram_addr = {bank_q, item_in.row, item_in.col};
					if (item_in.req_type == REQ_LOAD) begin
						ram_we = 1'b1;
						ram_wdata.ant = item_in.ant_in;
						ram_wdata.food = item_in.food_in;
						ram_wdata.food_flag = item_in.food_flag_in;
						ram_wdata.colony_flag = item_in.colony_flag_in;
					end else if (item_in.req_type == REQ_DIFFUSE) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				ram_addr = {bank_q, nr[SIDE_BITS-1:0], nc[SIDE_BITS-1:0]};
				if (last_pos) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DIV;
			ST_DIV: state_d = ST_FIX;
			ST_FIX: state_d = ST_MIX;
			ST_MIX: state_d = ST_WRITE;
			ST_WRITE: begin
				ram_we = 1'b1;
				ram_addr = {~bank_q, row_q, col_q};
				ram_wdata = new_cell;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			rd_s1 <= 1'b0;
			ctr_s1 <= 1'b0;
			dr_q <= '0;
			dc_q <= '0;
		end else begin
			if (accept && item_in.req_type == REQ_SWAP) begin
				bank_q <= ~bank_q;
			end
			rd_s1 <= (state_q == ST_READ) && nb_inside;
			ctr_s1 <= (state_q == ST_READ) && (dr_q == 2'd1) && (dc_q == 2'd1);
			if (accept) begin
				dr_q <= '0;
				dc_q <= '0;
			end else if (state_q == ST_READ) begin
				if (dc_q == 2'd2) begin
					dc_q <= '0;
					dr_q <= dr_q + 2'd1;
				end else begin
					dc_q <= dc_q + 2'd1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- grid memory
	gde_ram #(
		.WIDTH(CELL_W),
		.DEPTH(BANK_DEPTH)
	) u_grid (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------- datapath
	assign new_cell.ant = old_q.colony_flag ? CONC_BITS'(1 << (CONC_BITS - 1))
		: mix_finish(old_q.ant, mag_a_q, neg_a_q, evap_q);
	assign new_cell.food = old_q.food_flag ? CONC_BITS'(1 << (CONC_BITS - 1))
		: mix_finish(old_q.food, mag_f_q, neg_f_q, evap_q);
	assign new_cell.food_flag = old_q.food_flag;
	assign new_cell.colony_flag = old_q.colony_flag;

	assign diff_a = abs_diff(blur_a_q, old_q.ant);
	assign diff_f = abs_diff(blur_f_q, old_q.food);

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= item_in.row;
			col_q <= item_in.col;
			sum_a_q <= '0;
			sum_f_q <= '0;
			count_q <= '0;
		end else if (rd_s1) begin
			sum_a_q <= sum_a_q + SUM_W'(ram_rdata.ant);
			sum_f_q <= sum_f_q + SUM_W'(ram_rdata.food);
			count_q <= count_q + 4'd1;
		end
		if (ctr_s1) begin
			old_q <= ram_rdata;
		end
		// rounding offset folded in before the divide
		if (state_q == ST_DIV) begin
			x_a_q <= sum_a_q + SUM_W'(count_q >> 1);
			x_f_q <= sum_f_q + SUM_W'(count_q >> 1);
			prod_a_q <= PROD_W'(sum_a_q + SUM_W'(count_q >> 1)) * PROD_W'(recip(count_q));
			prod_f_q <= PROD_W'(sum_f_q + SUM_W'(count_q >> 1)) * PROD_W'(recip(count_q));
		end
		if (state_q == ST_FIX) begin
			blur_a_q <= div_fix(x_a_q, prod_a_q, count_q);
			blur_f_q <= div_fix(x_f_q, prod_f_q, count_q);
		end
		if (state_q == ST_MIX) begin
			neg_a_q <= diff_a[CONC_BITS];
			neg_f_q <= diff_f[CONC_BITS];
			mag_a_q <= MAG_W'(diff_a[CONC_BITS-1:0]) * MAG_W'(mix_q);
			mag_f_q <= MAG_W'(diff_f[CONC_BITS-1:0]) * MAG_W'(mix_q);
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (accept && !(item_in.req_type == REQ_DIFFUSE && item_inside))
				|| (state_q == ST_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			result_q.ant_out <= new_cell.ant;
			result_q.food_out <= new_cell.food;
			result_q.status <= STATUS_OK;
		end else if (accept) begin
			result_q.ant_out <= '0;
			result_q.food_out <= '0;
			if ((item_in.req_type == REQ_LOAD || item_in.req_type == REQ_DIFFUSE)
				&& !item_inside) begin
				result_q.status <= STATUS_OUTSIDE;
			end else begin
				result_q.status <= STATUS_OK;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

@@ design/gde_checker.sv @@
module gde_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input gde_pkg::item_t item_in,
	input logic result_valid,
	input gde_pkg::result_t result
);

	import gde_pkg::*;

	logic accept;
	assign accept = start & ~busy;

	// anything but a diffuse answers in the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item_in.req_type != REQ_DIFFUSE |=> result_valid)
		else $error("non-diffuse item gave no result in the next cycle");

	a_swap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item_in.req_type == REQ_SWAP |=> result == '0)
		else $error("swap result not all zero");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == STATUS_OUTSIDE |->
		result.ant_out == '0 && result.food_out == '0)
		else $error("outside-grid result carries concentrations");

	// a finished diffuse hands its result out as busy drops
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy dropped without a result");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !busy)
		else $error("busy rose without an item");

endmodule

bind grid_diffuse_evaporate_core gde_checker u_gde_checker (.*);
